>>> rtl/ibdq_pkg.sv
// Shared types, codes and tables for the intra block dequantizer.
package ibdq_pkg;

    localparam int COEFS_PER_BLOCK = 64;
    localparam int POS_W           = $clog2(COEFS_PER_BLOCK);
    localparam int MID_DEPTH_DEF   = 4;
    localparam int OUT_DEPTH_DEF   = 4;

    localparam logic [2:0] MODE_FRAME  = 3'd0;
    localparam logic [2:0] MODE_BLOCK  = 3'd1;
    localparam logic [2:0] MODE_CODED  = 3'd2;
    localparam logic [2:0] MODE_ESCAPE = 3'd3;
    localparam logic [2:0] MODE_EOB    = 3'd4;

    localparam logic CFG_QUANT_SCALE    = 1'b0;
    localparam logic CFG_STREAM_VERSION = 1'b1;

    localparam logic [15:0] QUANT_SCALE_RST    = 16'd1;
    localparam logic [15:0] STREAM_VERSION_RST = 16'd2;
    localparam logic [15:0] VERSION_PLAIN_MAX  = 16'd2;
    localparam logic [15:0] DC_PRED_RST        = 16'd128;
    localparam logic [15:0] DC_PLAIN_OFFSET    = 16'd1024;

    localparam logic [5:0] ZIGZAG [COEFS_PER_BLOCK] = '{
        6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
        6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
        6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
        6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
    };

    localparam logic [6:0] WEIGHT [COEFS_PER_BLOCK] = '{
        7'd8,  7'd16, 7'd19, 7'd22, 7'd26, 7'd27, 7'd29, 7'd34,
        7'd16, 7'd16, 7'd22, 7'd24, 7'd27, 7'd29, 7'd34, 7'd37,
        7'd19, 7'd22, 7'd26, 7'd27, 7'd29, 7'd34, 7'd34, 7'd38,
        7'd22, 7'd22, 7'd26, 7'd27, 7'd29, 7'd34, 7'd37, 7'd40,
        7'd22, 7'd26, 7'd27, 7'd29, 7'd32, 7'd35, 7'd40, 7'd48,
        7'd26, 7'd27, 7'd29, 7'd32, 7'd35, 7'd40, 7'd48, 7'd58,
        7'd26, 7'd27, 7'd29, 7'd34, 7'd38, 7'd46, 7'd56, 7'd69,
        7'd27, 7'd29, 7'd35, 7'd38, 7'd46, 7'd56, 7'd69, 7'd83
    };

    typedef enum logic [1:0] {
        KIND_PASS  = 2'd0,
        KIND_CODED = 2'd1,
        KIND_ESC   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  index;
        logic [2:0]  block;
        logic        error;
        logic        last;
        logic [15:0] value;
        logic        lvl_neg;
        logic [9:0]  lvl_abs;
        logic [6:0]  weight;
        logic        negative;
    } t_op;

    typedef struct packed {
        logic [5:0]  index;
        logic [15:0] value;
        logic [2:0]  block;
        logic        error;
        logic        last;
    } t_res;

endpackage

>>> rtl/ibdq_fifo.sv
// Small register queue used between the front, the back and the result port.
module ibdq_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [DW-1:0]                i_data,
    input  logic                         i_pop,
    output logic [DW-1:0]                o_data,
    output logic                         o_full,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // pointers wrap at DEPTH, so any depth works
    always_comb begin
        n_wr = r_wr;
        if (w_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : AW'(r_wr + 1'b1);
        end
        n_rd = r_rd;
        if (w_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : AW'(r_rd + 1'b1);
        end
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (w_pop && !w_push) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/ibdq_front.sv
// Token front end: scan position, DC handling, zigzag lookup, request classification.
module ibdq_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [2:0]           i_mode,
    input  logic [2:0]           i_block_number,
    input  logic signed [11:0]   i_dc_value,
    input  logic [5:0]           i_run,
    input  logic signed [9:0]    i_level,
    input  logic                 i_negative,
    input  logic [15:0]          i_stream_version,
    output logic                 o_wr,
    output ibdq_pkg::t_op        o_op
);
    import ibdq_pkg::*;

    logic [15:0]      r_pred [3];
    logic [15:0]      n_pred [3];
    logic [POS_W-1:0] r_scan, n_scan;
    logic [2:0]       r_block, n_block;
    logic             r_err, n_err;

    logic [POS_W:0]   w_pos;
    logic [5:0]       w_zz;
    logic [1:0]       w_comp;
    logic [15:0]      w_dc_ext;
    logic [15:0]      w_pred_sum;
    logic [15:0]      w_dc_plain;
    logic             w_predicted;

    assign w_pos       = {1'b0, r_scan} + (POS_W + 1)'(i_run) + 1'b1;
    assign w_zz        = ZIGZAG[w_pos[POS_W-1:0]];
    assign w_comp      = (i_block_number <= 3'd3) ? 2'd0 : ((i_block_number == 3'd4) ? 2'd1 : 2'd2);
    assign w_dc_ext    = 16'(i_dc_value);
    assign w_pred_sum  = r_pred[w_comp] + w_dc_ext;
    assign w_dc_plain  = {w_dc_ext[14:0], 1'b0} + DC_PLAIN_OFFSET;
    assign w_predicted = (i_stream_version > VERSION_PLAIN_MAX);

    always_comb begin
        n_pred  = r_pred;
        n_scan  = r_scan;
        n_block = r_block;
        n_err   = r_err;
        o_wr    = 1'b0;
        o_op    = '0;
        o_op.kind  = KIND_PASS;
        o_op.block = r_block;
        if (i_accept) begin
            unique case (i_mode)
                MODE_FRAME: begin
                    n_pred[0] = DC_PRED_RST;
                    n_pred[1] = DC_PRED_RST;
                    n_pred[2] = DC_PRED_RST;
                end
                MODE_BLOCK: begin
                    n_block     = i_block_number;
                    n_scan      = '0;
                    n_err       = 1'b0;
                    o_wr        = 1'b1;
                    o_op.block  = i_block_number;
                    o_op.index  = ZIGZAG[0];
                    if (w_predicted) begin
                        n_pred[w_comp] = w_pred_sum;
                        o_op.value     = {w_pred_sum[12:0], 3'b000};
                    end else begin
                        o_op.value = w_dc_plain;
                    end
                end
                MODE_CODED, MODE_ESCAPE: begin
                    o_wr = 1'b1;
                    if (r_err) begin
                        o_op.error = 1'b1;
                    end else if (w_pos[POS_W]) begin
                        n_err      = 1'b1;
                        o_op.error = 1'b1;
                    end else begin
                        n_scan        = w_pos[POS_W-1:0];
                        o_op.kind     = (i_mode == MODE_CODED) ? KIND_CODED : KIND_ESC;
                        o_op.index    = w_zz;
                        o_op.weight   = WEIGHT[w_zz];
                        o_op.lvl_neg  = i_level[9];
                        o_op.lvl_abs  = i_level[9] ? 10'(-i_level) : 10'(i_level);
                        o_op.negative = i_negative;
                    end
                end
                MODE_EOB: begin
                    o_wr       = 1'b1;
                    o_op.last  = 1'b1;
                    o_op.error = r_err;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred[0] <= DC_PRED_RST;
            r_pred[1] <= DC_PRED_RST;
            r_pred[2] <= DC_PRED_RST;
            r_scan    <= '0;
            r_block   <= '0;
            r_err     <= 1'b0;
        end else begin
            r_pred  <= n_pred;
            r_scan  <= n_scan;
            r_block <= n_block;
            r_err   <= n_err;
        end
    end

endmodule

>>> rtl/ibdq_back.sv
// Back end: two multiply stages and rounding, feeding the result queue.
module ibdq_back #(
    parameter int OUT_DEPTH = ibdq_pkg::OUT_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [15:0]                     i_quant_scale,
    input  logic                            i_op_valid,
    input  ibdq_pkg::t_op                   i_op,
    output logic                            o_op_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]  i_out_count,
    output logic                            o_res_push,
    output ibdq_pkg::t_res                  o_res
);
    import ibdq_pkg::*;

    localparam int CW = $clog2(OUT_DEPTH + 1);

    logic        r_a_valid;
    t_op         r_a_op;
    logic [22:0] r_a_qw;
    logic        r_b_valid;
    t_op         r_b_op;
    logic [32:0] r_b_prod;

    logic [CW:0]  w_used;
    logic [18:0]  w_rnd;
    logic [15:0]  w_mag_c;
    logic [15:0]  w_mag_e;
    logic         w_sign_c;
    logic         w_even_nz;

    // Only take a request when its result is sure to fit in the result queue.
    assign w_used   = {1'b0, i_out_count} + (CW + 1)'(r_a_valid) + (CW + 1)'(r_b_valid);
    assign o_op_pop = i_op_valid && (w_used < (CW + 1)'(OUT_DEPTH));

    // Coded: floor of the signed product over 8; escape: odd toward zero.
    assign w_rnd     = r_b_prod[18:0] + 19'd7;
    assign w_mag_c   = r_b_op.lvl_neg ? w_rnd[18:3] : r_b_prod[18:3];
    assign w_sign_c  = r_b_op.lvl_neg ^ r_b_op.negative;
    assign w_even_nz = (|r_b_prod[32:3]) && !r_b_prod[3];
    assign w_mag_e   = r_b_prod[18:3] - {15'd0, w_even_nz};

    assign o_res_push = r_b_valid;

    always_comb begin
        o_res.index = r_b_op.index;
        o_res.block = r_b_op.block;
        o_res.error = r_b_op.error;
        o_res.last  = r_b_op.last;
        unique case (r_b_op.kind)
            KIND_CODED: o_res.value = w_sign_c ? 16'(-w_mag_c) : w_mag_c;
            KIND_ESC:   o_res.value = r_b_op.lvl_neg ? 16'(-w_mag_e) : w_mag_e;
            default:    o_res.value = r_b_op.value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= o_op_pop;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_op   <= i_op;
        r_a_qw   <= {7'd0, i_quant_scale} * {16'd0, i_op.weight};
        r_b_op   <= r_a_op;
        r_b_prod <= {23'd0, r_a_op.lvl_abs} * {10'd0, r_a_qw};
    end

endmodule

>>> rtl/intra_block_dequantizer.sv
// Intra block dequantizer: tokens in, dequantized natural-order coefficients out.
// A result passes through the request queue, the two multiply stages and the result queue.
// Throughput: one token per cycle while the request queue is not full; back end is a two-stage multiply pipeline.
// Reset (synchronous, active low): queues empty, scan position and block error
// cleared, DC predictors 128, quant_scale 1, stream_version 2.
module intra_block_dequantizer #(
    parameter int MID_DEPTH = ibdq_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = ibdq_pkg::OUT_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [2:0]          i_mode,
    input  logic [2:0]          i_block_number,
    input  logic signed [11:0]  i_dc_value,
    input  logic [5:0]          i_run,
    input  logic signed [9:0]   i_level,
    input  logic                i_negative,
    output logic                empty,
    input  logic                pop,
    output logic [5:0]          o_coef_index,
    output logic signed [15:0]  o_coef_value,
    output logic [2:0]          o_out_block,
    output logic                o_error,
    output logic                o_last,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import ibdq_pkg::*;

    localparam int OP_W  = $bits(t_op);
    localparam int RES_W = $bits(t_res);

    logic [15:0] r_quant_scale;
    logic [15:0] r_stream_version;

    logic                          w_accept;
    logic                          w_front_wr;
    t_op                           w_front_op;
    t_op                           w_mid_op;
    logic                          w_mid_empty;
    logic                          w_mid_pop;
    logic [$clog2(MID_DEPTH+1)-1:0] w_mid_count;
    logic                          w_res_push;
    t_res                          w_res_in;
    t_res                          w_res_out;
    logic                          w_out_full;
    logic [$clog2(OUT_DEPTH+1)-1:0] w_out_count;

    assign w_accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant_scale    <= QUANT_SCALE_RST;
            r_stream_version <= STREAM_VERSION_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_QUANT_SCALE:    r_quant_scale    <= i_cfg_data;
                CFG_STREAM_VERSION: r_stream_version <= i_cfg_data;
            endcase
        end
    end

    ibdq_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_mode           (i_mode),
        .i_block_number   (i_block_number),
        .i_dc_value       (i_dc_value),
        .i_run            (i_run),
        .i_level          (i_level),
        .i_negative       (i_negative),
        .i_stream_version (r_stream_version),
        .o_wr             (w_front_wr),
        .o_op             (w_front_op)
    );

    ibdq_fifo #(
        .DW    (OP_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_wr),
        .i_data  (w_front_op),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_op),
        .o_full  (full),
        .o_empty (w_mid_empty),
        .o_count (w_mid_count)
    );

    ibdq_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_quant_scale (r_quant_scale),
        .i_op_valid    (!w_mid_empty),
        .i_op          (w_mid_op),
        .o_op_pop      (w_mid_pop),
        .i_out_count   (w_out_count),
        .o_res_push    (w_res_push),
        .o_res         (w_res_in)
    );

    ibdq_fifo #(
        .DW    (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_full  (w_out_full),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    assign o_coef_index = w_res_out.index;
    assign o_coef_value = w_res_out.value;
    assign o_out_block  = w_res_out.block;
    assign o_error      = w_res_out.error;
    assign o_last       = w_res_out.last;

    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_res_push && w_out_full))
        else $error("result queue overflow");

    a_mid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_count <= ($clog2(MID_DEPTH+1))'(MID_DEPTH))
        else $error("request queue count out of range");

    a_eob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |-> (o_coef_index == 6'd0 && o_coef_value == 16'sd0))
        else $error("end of block result carries a coefficient");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error) |-> (o_coef_index == 6'd0 && o_coef_value == 16'sd0))
        else $error("error result carries a coefficient");

    a_empty_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_front_wr && w_accept) |=> (w_mid_count != '0))
        else $error("accepted request lost");

endmodule
